// File: hw/rtl/ecou_pkg.sv
package ecou_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_COUNT       = 24;

   // angles in Q9.8 degrees
   localparam int YAW_HALF_TURN  = 46080;
   localparam int YAW_FULL_TURN  = 92160;
   localparam int QUARTER_TURN   = 23040;
   localparam int PITCH_LIMIT    = 22784;
   localparam int ANG18_MAX      = 131071;
   localparam int ANG18_MIN      = -131072;
   localparam int POS_MAX        = 8388607;
   localparam int POS_MIN        = -8388608;
   localparam int ONE_Q14        = 16384;
   localparam int CORDIC_INV_GAIN = 652032874;

   localparam int YAW_RESET      = -23040;
   localparam int SPEED_RESET    = 640;
   localparam int SENS_RESET     = 6554;

   // register indexes
   localparam logic [3:0] REG_MOVE_SPEED = 4'd0;
   localparam logic [3:0] REG_LOOK_SENS  = 4'd1;
   localparam logic [3:0] REG_WUP_X      = 4'd2;
   localparam logic [3:0] REG_WUP_Y      = 4'd3;
   localparam logic [3:0] REG_WUP_Z      = 4'd4;
   localparam logic [3:0] REG_START_X    = 4'd5;
   localparam logic [3:0] REG_START_Y    = 4'd6;
   localparam logic [3:0] REG_START_Z    = 4'd7;

   localparam logic REQ_LOOK = 1'b0;
   localparam logic REQ_MOVE = 1'b1;

   localparam logic [1:0] DIR_FWD   = 2'd0;
   localparam logic [1:0] DIR_BACK  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   localparam logic OP_SQRT = 1'b0;
   localparam logic OP_DIV  = 1'b1;

   typedef struct packed {
      logic start;
      logic op;
   } unit_cmd_type;

   // arctan(2^-i) in degrees, Q.16
   function automatic logic signed [26:0] atan_val(input logic [4:0] i);
      logic signed [26:0] v;
      begin
         case (i)
            5'd0:  v = 27'sd2949120;
            5'd1:  v = 27'sd1740967;
            5'd2:  v = 27'sd919879;
            5'd3:  v = 27'sd466945;
            5'd4:  v = 27'sd234379;
            5'd5:  v = 27'sd117305;
            5'd6:  v = 27'sd58666;
            5'd7:  v = 27'sd29335;
            5'd8:  v = 27'sd14668;
            5'd9:  v = 27'sd7334;
            5'd10: v = 27'sd3667;
            5'd11: v = 27'sd1833;
            5'd12: v = 27'sd917;
            5'd13: v = 27'sd458;
            5'd14: v = 27'sd229;
            5'd15: v = 27'sd115;
            5'd16: v = 27'sd57;
            5'd17: v = 27'sd29;
            5'd18: v = 27'sd14;
            5'd19: v = 27'sd7;
            5'd20: v = 27'sd4;
            5'd21: v = 27'sd2;
            5'd22: v = 27'sd1;
            default: v = 27'sd0;
         endcase
         return v;
      end
   endfunction

endpackage

// File: hw/rtl/ecou_cordic.sv
module ecou_cordic #(
   parameter int CORDIC_STEPS = ecou_pkg::CORDIC_STEPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [17:0]  angle,
   output logic                done,
   output logic signed [33:0]  sin_out,
   output logic signed [33:0]  cos_out
);
   import ecou_pkg::*;

   localparam int IW = $clog2(CORDIC_STEPS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;
   logic [IW-1:0]       cnt_ff, cnt_in;
   logic signed [33:0]  x_ff, x_in, y_ff, y_in;
   logic signed [26:0]  z_ff, z_in;

   always_comb begin
      logic signed [18:0] a19;
      logic signed [18:0] zr;
      logic signed [33:0] dx, dy;
      logic signed [26:0] at;
      a19 = 19'(angle);
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      zr      = a19;
      dx      = y_ff >>> cnt_ff;
      dy      = x_ff >>> cnt_ff;
      at      = atan_val(5'(cnt_ff));
      if (start) begin
         // wrap into a half-open turn, then fold into the right half plane
         if (a19 >= 19'sd46080)
            zr = a19 - 19'(YAW_FULL_TURN);
         else if (a19 < -19'sd46080)
            zr = a19 + 19'(YAW_FULL_TURN);
         neg_in = 1'b0;
         if (zr > 19'(QUARTER_TURN)) begin
            zr = zr - 19'(YAW_HALF_TURN);
            neg_in = 1'b1;
         end else if (zr < -19'sd23040) begin
            zr = zr + 19'(YAW_HALF_TURN);
            neg_in = 1'b1;
         end
         z_in    = 27'(zr) <<< 8;
         x_in    = 34'(CORDIC_INV_GAIN);
         y_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == IW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign done    = done_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;

endmodule

// File: hw/rtl/ecou_root_div.sv
module ecou_root_div (
   input  logic                       clock,
   input  logic                       reset,
   input  ecou_pkg::unit_cmd_type     cmd,
   input  logic [63:0]                radicand,
   input  logic [47:0]                numer,
   input  logic [31:0]                denom,
   output logic                       done,
   output logic [31:0]                result
);
   import ecou_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        op_ff, op_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] s_ff, s_in, res_ff, res_in, bit_ff, bit_in;

   always_comb begin
      logic [63:0] trial;
      logic        ge;
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      s_in    = s_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      trial   = (op_ff == OP_DIV) ? bit_ff : res_ff + bit_ff;
      ge      = s_ff >= trial;
      if (cmd.start) begin
         op_in   = cmd.op;
         cnt_in  = '0;
         res_in  = '0;
         busy_in = 1'b1;
         if (cmd.op == OP_DIV) begin
            s_in   = 64'(numer);
            bit_in = 64'(denom) << 15;
         end else begin
            s_in   = radicand;
            bit_in = 64'd1 << 62;
         end
      end else if (busy_ff) begin
         if (ge)
            s_in = s_ff - trial;
         if (op_ff == OP_DIV) begin
            res_in = {res_ff[62:0], ge};
            bit_in = bit_ff >> 1;
         end else begin
            res_in = (res_ff >> 1) + (ge ? bit_ff : 64'd0);
            bit_in = bit_ff >> 2;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ((op_ff == OP_DIV) ? 5'd15 : 5'd31)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      s_ff   <= s_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done   = done_ff;
   assign result = res_ff[31:0];

endmodule

// File: hw/rtl/euler_camera_orientation_update.sv
// sequence: a move transaction runs the velocity product, then a multiply and add per axis,
// before rsp_tvalid; a look transaction runs the two cordic passes and three
// normalizations (square root 32 steps, 3 divides of 16 steps) before rsp_tvalid
// throughput: one transaction at a time, req_tready is high only when idle
// reset: synchronous, restores yaw -90, pitch 0, default registers, basis
// vectors and a zero position
module euler_camera_orientation_update #(
   parameter int CORDIC_STEPS = ecou_pkg::CORDIC_STEPS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // x_offset, y_offset, clamp_pitch, delta_time, move_dir
   input  logic [55:0]   req_tdata,
   // req_type
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // pos_x, pos_y, pos_z, front_x..z, right_x..z, up_x..z
   output logic [215:0]  rsp_tdata,
   input  logic          csr_we,
   input  logic [3:0]    csr_index,
   input  logic [23:0]   csr_wdata
);
   import ecou_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_LK_MX   = 5'd1;
   localparam logic [4:0] S_LK_YAW  = 5'd2;
   localparam logic [4:0] S_LK_PIT  = 5'd3;
   localparam logic [4:0] S_CD_YAW  = 5'd4;
   localparam logic [4:0] S_CD_PIT  = 5'd5;
   localparam logic [4:0] S_FR_M0   = 5'd6;
   localparam logic [4:0] S_FR_M1   = 5'd7;
   localparam logic [4:0] S_FR_M2   = 5'd8;
   localparam logic [4:0] S_NM_SQ   = 5'd9;
   localparam logic [4:0] S_NM_ACC  = 5'd10;
   localparam logic [4:0] S_NM_ROOT = 5'd11;
   localparam logic [4:0] S_NM_DST  = 5'd12;
   localparam logic [4:0] S_NM_DIV  = 5'd13;
   localparam logic [4:0] S_NM_CMT  = 5'd14;
   localparam logic [4:0] S_NM_NEXT = 5'd15;
   localparam logic [4:0] S_CR_A    = 5'd16;
   localparam logic [4:0] S_CR_B    = 5'd17;
   localparam logic [4:0] S_CR_C    = 5'd18;
   localparam logic [4:0] S_MV_VEL  = 5'd19;
   localparam logic [4:0] S_MV_LD   = 5'd20;
   localparam logic [4:0] S_MV_MUL  = 5'd21;
   localparam logic [4:0] S_MV_ADD  = 5'd22;
   localparam logic [4:0] S_DONE    = 5'd23;

   localparam logic [1:0] PH_FRONT = 2'd0;
   localparam logic [1:0] PH_RIGHT = 2'd1;
   localparam logic [1:0] PH_UP    = 2'd2;

   function automatic logic [1:0] next3(input logic [1:0] k);
      return (k == 2'd2) ? 2'd0 : k + 2'd1;
   endfunction

   logic [4:0]          state_ff, state_in;
   logic [15:0]         speed_ff, sens_ff;
   logic signed [15:0]  wup_ff [3];
   logic signed [17:0]  yaw_ff, yaw_in, pitch_ff, pitch_in;
   logic signed [23:0]  pos_ff [3];
   logic signed [23:0]  pos_in;
   logic signed [15:0]  front_ff [3];
   logic signed [15:0]  right_ff [3];
   logic signed [15:0]  up_ff [3];
   logic                clamp_ff;
   logic signed [15:0]  xo_ff, yo_ff;
   logic [15:0]         dt_ff;
   logic [1:0]          dir_ff;
   logic signed [65:0]  prod_ff, prod_in;
   logic signed [65:0]  acc_ff, acc_in;
   logic signed [32:0]  tvec_ff [3];
   logic signed [15:0]  nvec_ff [3];
   logic [1:0]          k_ff, k_in, phase_ff, phase_in;
   logic [31:0]         len_ff, vel_ff;
   logic signed [33:0]  sy_ff, cy_ff, sp_ff, cp_ff;
   logic                rsp_tvalid_ff;
   logic [215:0]        rsp_tdata_ff;

   logic signed [32:0]  mul_a, mul_b;
   logic                cd_start, cd_done;
   logic signed [17:0]  cd_angle;
   logic signed [33:0]  cd_sin, cd_cos;
   unit_cmd_type        rd_cmd;
   logic                rd_done;
   logic [31:0]         rd_result;
   logic [47:0]         rd_numer;

   logic [1:0]          k1, k2;
   logic signed [15:0]  ca [3];
   logic signed [15:0]  cb [3];
   logic signed [15:0]  mv [3];
   logic signed [65:0]  rnd16, rnd30;
   logic [32:0]         mag;
   logic                accept, rsp_free;

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;
   assign k1       = next3(k_ff);
   assign k2       = next3(k1);
   assign rnd16    = (prod_ff + (66'sd1 <<< 15)) >>> 16;
   assign rnd30    = (prod_ff + (66'sd1 <<< 29)) >>> 30;
   assign mag      = tvec_ff[k_ff] < 0 ? 33'(-tvec_ff[k_ff]) : 33'(tvec_ff[k_ff]);
   assign rd_numer = {2'b00, mag[31:0], 14'b0} + 48'(len_ff >> 1);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ca[i] = (phase_ff == PH_RIGHT) ? front_ff[i] : right_ff[i];
         cb[i] = (phase_ff == PH_RIGHT) ? wup_ff[i] : front_ff[i];
         mv[i] = (dir_ff == DIR_FWD || dir_ff == DIR_BACK) ? front_ff[i] : right_ff[i];
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_LK_MX: begin
            mul_a = 33'(xo_ff);
            mul_b = {17'b0, sens_ff};
         end
         S_LK_YAW: begin
            mul_a = 33'(yo_ff);
            mul_b = {17'b0, sens_ff};
         end
         S_FR_M0: begin
            mul_a = cy_ff[32:0];
            mul_b = cp_ff[32:0];
         end
         S_FR_M1: begin
            mul_a = sy_ff[32:0];
            mul_b = cp_ff[32:0];
         end
         S_CR_A: begin
            mul_a = 33'(ca[k1]);
            mul_b = 33'(cb[k2]);
         end
         S_CR_B: begin
            mul_a = 33'(ca[k2]);
            mul_b = 33'(cb[k1]);
         end
         S_NM_SQ: begin
            mul_a = tvec_ff[k_ff];
            mul_b = tvec_ff[k_ff];
         end
         S_MV_VEL: begin
            mul_a = {17'b0, speed_ff};
            mul_b = {17'b0, dt_ff};
         end
         S_MV_MUL: begin
            mul_a = 33'(mv[k_ff]);
            mul_b = {1'b0, vel_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // angle update
   always_comb begin
      logic signed [18:0] y19, p19;
      y19 = 19'(yaw_ff) + 19'(rnd16);
      if (y19 >= 19'sd46080)
         y19 = y19 - 19'(YAW_FULL_TURN);
      else if (y19 < -19'sd46080)
         y19 = y19 + 19'(YAW_FULL_TURN);
      yaw_in = 18'(y19);
      p19 = 19'(pitch_ff) + 19'(rnd16);
      if (clamp_ff) begin
         if (p19 > 19'(PITCH_LIMIT))
            p19 = 19'(PITCH_LIMIT);
         else if (p19 < -19'sd22784)
            p19 = -19'sd22784;
      end else begin
         if (p19 > 19'(ANG18_MAX))
            p19 = 19'(ANG18_MAX);
         else if (p19 < 19'(ANG18_MIN))
            p19 = 19'(ANG18_MIN);
      end
      pitch_in = 18'(p19);
   end

   // position step with saturation
   always_comb begin
      logic signed [25:0] d26, s26;
      d26 = 26'($signed(rnd30[18:0]));
      if (dir_ff == DIR_FWD || dir_ff == DIR_RIGHT)
         s26 = 26'(pos_ff[k_ff]) + d26;
      else
         s26 = 26'(pos_ff[k_ff]) - d26;
      if (s26 > 26'(POS_MAX))
         pos_in = 24'(POS_MAX);
      else if (s26 < 26'(POS_MIN))
         pos_in = 24'(POS_MIN);
      else
         pos_in = 24'(s26);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      phase_in = phase_ff;
      acc_in   = acc_ff;
      cd_start = 1'b0;
      cd_angle = yaw_ff;
      rd_cmd   = '{start: 1'b0, op: OP_SQRT};
      case (state_ff)
         S_IDLE: begin
            if (accept)
               state_in = (req_tuser == REQ_MOVE) ? S_MV_VEL : S_LK_MX;
         end
         S_LK_MX:  state_in = S_LK_YAW;
         S_LK_YAW: state_in = S_LK_PIT;
         S_LK_PIT: begin
            cd_start = 1'b1;
            cd_angle = yaw_ff;
            state_in = S_CD_YAW;
         end
         S_CD_YAW: begin
            if (cd_done) begin
               cd_start = 1'b1;
               cd_angle = pitch_ff;
               state_in = S_CD_PIT;
            end
         end
         S_CD_PIT: begin
            if (cd_done)
               state_in = S_FR_M0;
         end
         S_FR_M0: state_in = S_FR_M1;
         S_FR_M1: state_in = S_FR_M2;
         S_FR_M2: begin
            phase_in = PH_FRONT;
            k_in     = 2'd0;
            state_in = S_NM_SQ;
         end
         S_NM_SQ: state_in = S_NM_ACC;
         S_NM_ACC: begin
            acc_in = ((k_ff == 2'd0) ? 66'sd0 : acc_ff) + prod_ff;
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = S_NM_ROOT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_NM_SQ;
            end
            if (k_ff == 2'd2)
               rd_cmd = '{start: 1'b1, op: OP_SQRT};
         end
         S_NM_ROOT: begin
            if (rd_done)
               state_in = (rd_result == 32'd0) ? S_NM_NEXT : S_NM_DST;
         end
         S_NM_DST: begin
            rd_cmd   = '{start: 1'b1, op: OP_DIV};
            state_in = S_NM_DIV;
         end
         S_NM_DIV: begin
            if (rd_done) begin
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = S_NM_CMT;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_NM_DST;
               end
            end
         end
         S_NM_CMT: state_in = S_NM_NEXT;
         S_NM_NEXT: begin
            k_in = 2'd0;
            if (phase_ff == PH_FRONT) begin
               phase_in = PH_RIGHT;
               state_in = S_CR_A;
            end else if (phase_ff == PH_RIGHT) begin
               phase_in = PH_UP;
               state_in = S_CR_A;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CR_A: state_in = S_CR_B;
         S_CR_B: begin
            acc_in   = prod_ff;
            state_in = S_CR_C;
         end
         S_CR_C: begin
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = S_NM_SQ;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_CR_A;
            end
         end
         S_MV_VEL: state_in = S_MV_LD;
         S_MV_LD: begin
            k_in     = 2'd0;
            state_in = S_MV_MUL;
         end
         S_MV_MUL: state_in = S_MV_ADD;
         S_MV_ADD: begin
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = S_DONE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_MV_MUL;
            end
         end
         S_DONE: begin
            if (rsp_free)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         k_ff          <= 2'd0;
         phase_ff      <= PH_FRONT;
         rsp_tvalid_ff <= 1'b0;
         speed_ff      <= 16'(SPEED_RESET);
         sens_ff       <= 16'(SENS_RESET);
         wup_ff[0]     <= '0;
         wup_ff[1]     <= 16'(ONE_Q14);
         wup_ff[2]     <= '0;
         yaw_ff        <= 18'(YAW_RESET);
         pitch_ff      <= '0;
         for (int i = 0; i < 3; i++)
            pos_ff[i] <= '0;
         front_ff[0]   <= '0;
         front_ff[1]   <= '0;
         front_ff[2]   <= -16'(ONE_Q14);
         right_ff[0]   <= 16'(ONE_Q14);
         right_ff[1]   <= '0;
         right_ff[2]   <= '0;
         up_ff[0]      <= '0;
         up_ff[1]      <= 16'(ONE_Q14);
         up_ff[2]      <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         phase_ff <= phase_in;

         if (csr_we) begin
            case (csr_index)
               REG_MOVE_SPEED: speed_ff  <= csr_wdata[15:0];
               REG_LOOK_SENS:  sens_ff   <= csr_wdata[15:0];
               REG_WUP_X:      wup_ff[0] <= csr_wdata[15:0];
               REG_WUP_Y:      wup_ff[1] <= csr_wdata[15:0];
               REG_WUP_Z:      wup_ff[2] <= csr_wdata[15:0];
               REG_START_X:    pos_ff[0] <= csr_wdata;
               REG_START_Y:    pos_ff[1] <= csr_wdata;
               REG_START_Z:    pos_ff[2] <= csr_wdata;
               default: ;
            endcase
         end

         if (state_ff == S_LK_YAW)
            yaw_ff <= yaw_in;
         if (state_ff == S_LK_PIT)
            pitch_ff <= pitch_in;
         if (state_ff == S_MV_ADD)
            pos_ff[k_ff] <= pos_in;

         // a zero length keeps the old vector: the commit state is skipped
         if (state_ff == S_NM_CMT) begin
            for (int i = 0; i < 3; i++) begin
               if (phase_ff == PH_FRONT)
                  front_ff[i] <= nvec_ff[i];
               else if (phase_ff == PH_RIGHT)
                  right_ff[i] <= nvec_ff[i];
               else
                  up_ff[i] <= nvec_ff[i];
            end
         end

         if (state_ff == S_DONE && rsp_free)
            rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_tvalid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (accept) begin
         xo_ff    <= req_tdata[15:0];
         yo_ff    <= req_tdata[31:16];
         clamp_ff <= req_tdata[32];
         dt_ff    <= req_tdata[48:33];
         dir_ff   <= req_tdata[50:49];
      end
      if (state_ff == S_CD_YAW && cd_done) begin
         sy_ff <= cd_sin;
         cy_ff <= cd_cos;
      end
      if (state_ff == S_CD_PIT && cd_done) begin
         sp_ff <= cd_sin;
         cp_ff <= cd_cos;
      end
      if (state_ff == S_FR_M1)
         tvec_ff[0] <= rnd30[32:0];
      if (state_ff == S_FR_M2) begin
         tvec_ff[2] <= rnd30[32:0];
         tvec_ff[1] <= sp_ff[32:0];
      end
      if (state_ff == S_CR_C)
         tvec_ff[k_ff] <= acc_ff[32:0] - prod_ff[32:0];
      if (state_ff == S_NM_ROOT && rd_done)
         len_ff <= rd_result;
      if (state_ff == S_NM_DIV && rd_done)
         nvec_ff[k_ff] <= tvec_ff[k_ff] < 0 ? -rd_result[15:0] : rd_result[15:0];
      if (state_ff == S_MV_LD)
         vel_ff <= prod_ff[31:0];
      if (state_ff == S_DONE && rsp_free)
         rsp_tdata_ff <= {up_ff[2], up_ff[1], up_ff[0],
                          right_ff[2], right_ff[1], right_ff[0],
                          front_ff[2], front_ff[1], front_ff[0],
                          pos_ff[2], pos_ff[1], pos_ff[0]};
   end

   ecou_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cd_start),
      .angle   (cd_angle),
      .done    (cd_done),
      .sin_out (cd_sin),
      .cos_out (cd_cos)
   );

   ecou_root_div u_root_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (rd_cmd),
      .radicand (acc_in[63:0]),
      .numer    (rd_numer),
      .denom    (len_ff),
      .done     (rd_done),
      .result   (rd_result)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// File: hw/rtl/ecou_checker.sv
module ecou_checker (
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [215:0]  rsp_tdata
);

   // a pending result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or dropped while stalled");

   // busy right after a request is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // an offered result carries known data
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown(rsp_tdata))
      else $error("result data unknown");

   // nothing to deliver after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind euler_camera_orientation_update ecou_checker u_ecou_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ecou_pkg::*;

   typedef struct {
      logic        kind;
      logic [15:0] xo;
      logic [15:0] yo;
      logic        clamp;
      logic [15:0] dt;
      logic [1:0]  dir;
   } cam_req_type;

   typedef struct {
      logic        is_cfg;
      logic        is_wait;
      logic [3:0]  idx;
      logic [23:0] val;
      cam_req_type r;
   } cam_op_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [55:0]   req_tdata = '0;
   logic          req_tuser = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [215:0]  rsp_tdata;
   logic          csr_we = 1'b0;
   logic [3:0]    csr_index = '0;
   logic [23:0]   csr_wdata = '0;

   euler_camera_orientation_update DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   longint speed_q, sens_q, wup[3];
   longint yaw_q, pitch_q, pos_q[3], frt[3], rgt[3], upv[3];
   logic [215:0] pose_exp_q[$];
   cam_op_type   pending_ops[$];
   bit           failed = 0;

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint rnd(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint int_sqrt(longint unsigned s);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s -= res + b;
            res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return res;
   endfunction

   function automatic bit unit_vec(input longint v[3], output longint o[3]);
      longint unsigned sum, len, mag, q;
      sum = 0;
      for (int k = 0; k < 3; k++) sum += longint'(v[k] * v[k]);
      len = int_sqrt(sum);
      if (len == 0) return 0;
      for (int k = 0; k < 3; k++) begin
         mag = v[k] < 0 ? -v[k] : v[k];
         q = (mag * 16384 + len / 2) / len;
         if (q > 32767) q = 32767;
         o[k] = v[k] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
   endfunction

   function automatic void sin_cos(input longint a, output longint sn, output longint cs);
      longint fullt, halft, quart, x, y, z, dx, dy;
      bit neg;
      fullt = 360 * 65536;
      halft = 180 * 65536;
      quart = 90 * 65536;
      x = CORDIC_INV_GAIN;
      y = 0;
      neg = 0;
      z = (a + halft) % fullt;
      if (z < 0) z += fullt;
      z -= halft;
      if (z > quart) begin
         z -= halft;
         neg = 1;
      end else if (z < -quart) begin
         z += halft;
         neg = 1;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_COUNT; i++) begin
         dx = asr(y, i);
         dy = asr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_val(5'(i)));
         end else begin
            x += dx; y -= dy; z += longint'(atan_val(5'(i)));
         end
      end
      cs = neg ? -x : x;
      sn = neg ? -y : y;
   endfunction

   function automatic void cross3(input longint a[3], input longint b[3], output longint r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic void rebuild_basis();
      longint sy, cy, sp, cp, t[3], n[3];
      sin_cos(yaw_q * 256, sy, cy);
      sin_cos(pitch_q * 256, sp, cp);
      t[0] = rnd(cy * cp, 30);
      t[1] = sp;
      t[2] = rnd(sy * cp, 30);
      if (unit_vec(t, n)) frt = n;
      cross3(frt, wup, t);
      if (unit_vec(t, n)) rgt = n;
      cross3(rgt, frt, t);
      if (unit_vec(t, n)) upv = n;
   endfunction

   function automatic void camera_reset();
      speed_q = SPEED_RESET;
      sens_q = SENS_RESET;
      wup = '{0, ONE_Q14, 0};
      yaw_q = YAW_RESET;
      pitch_q = 0;
      pos_q = '{0, 0, 0};
      frt = '{0, 0, -ONE_Q14};
      rgt = '{ONE_Q14, 0, 0};
      upv = '{0, ONE_Q14, 0};
   endfunction

   function automatic void apply_csr(logic [3:0] idx, logic [23:0] v);
      case (idx)
         REG_MOVE_SPEED: speed_q = v[15:0];
         REG_LOOK_SENS:  sens_q = v[15:0];
         REG_WUP_X:      wup[0] = longint'($signed(v[15:0]));
         REG_WUP_Y:      wup[1] = longint'($signed(v[15:0]));
         REG_WUP_Z:      wup[2] = longint'($signed(v[15:0]));
         REG_START_X:    pos_q[0] = longint'($signed(v));
         REG_START_Y:    pos_q[1] = longint'($signed(v));
         REG_START_Z:    pos_q[2] = longint'($signed(v));
         default: ;
      endcase
   endfunction

   function automatic logic [215:0] predict_pose(cam_req_type r);
      longint p, vel, d, v[3];
      logic [215:0] o;
      if (r.kind == REQ_LOOK) begin
         yaw_q += rnd(longint'($signed(r.xo)) * sens_q, 16);
         if (yaw_q >= YAW_HALF_TURN) yaw_q -= YAW_FULL_TURN;
         else if (yaw_q < -YAW_HALF_TURN) yaw_q += YAW_FULL_TURN;
         p = pitch_q + rnd(longint'($signed(r.yo)) * sens_q, 16);
         if (r.clamp) p = clip(p, -PITCH_LIMIT, PITCH_LIMIT);
         else p = clip(p, ANG18_MIN, ANG18_MAX);
         pitch_q = p;
         rebuild_basis();
      end else begin
         vel = speed_q * longint'(r.dt);
         v = (r.dir == DIR_FWD || r.dir == DIR_BACK) ? frt : rgt;
         for (int k = 0; k < 3; k++) begin
            d = rnd(v[k] * vel, 30);
            pos_q[k] = clip((r.dir == DIR_FWD || r.dir == DIR_RIGHT) ?
                            pos_q[k] + d : pos_q[k] - d, POS_MIN, POS_MAX);
         end
      end
      for (int k = 0; k < 3; k++) begin
         o[24*k +: 24] = pos_q[k][23:0];
         o[72 + 16*k +: 16] = frt[k][15:0];
         o[120 + 16*k +: 16] = rgt[k][15:0];
         o[168 + 16*k +: 16] = upv[k][15:0];
      end
      return o;
   endfunction

   function automatic int gap_len();
      int g;
      g = $urandom_range(0, 99);
      if (g < 50) return 0;
      if (g < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // stimulus builders
   function automatic void add_req(logic kind, logic [15:0] xo, logic [15:0] yo,
                                   logic clamp, logic [15:0] dt, logic [1:0] dir);
      cam_op_type o;
      o = '{default: '0};
      o.r = '{kind, xo, yo, clamp, dt, dir};
      pending_ops.push_back(o);
   endfunction

   function automatic void add_cfg(logic [3:0] idx, logic [23:0] v);
      cam_op_type o;
      o = '{default: '0};
      o.is_wait = 1;
      pending_ops.push_back(o);
      o.is_wait = 0;
      o.is_cfg = 1;
      o.idx = idx;
      o.val = v;
      pending_ops.push_back(o);
   endfunction

   function automatic void add_random(int n);
      int mode;
      for (int i = 0; i < n; i++) begin
         mode = $urandom_range(0, 9);
         if (mode < 5)
            add_req(REQ_LOOK, (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000),
                    (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000),
                    $urandom_range(0, 3) != 0, 16'($urandom), 2'($urandom));
         else
            add_req(REQ_MOVE, 16'($urandom), 16'($urandom), 1'($urandom),
                    16'($urandom), 2'($urandom));
      end
   endfunction

   initial begin
      camera_reset();
      // directed: every direction, field extremes, pitch clamp and wrap
      add_req(REQ_MOVE, 0, 0, 0, 16'hFFFF, DIR_FWD);
      add_req(REQ_MOVE, 0, 0, 0, 16'hFFFF, DIR_BACK);
      add_req(REQ_MOVE, 0, 0, 0, 16'hFFFF, DIR_LEFT);
      add_req(REQ_MOVE, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, DIR_RIGHT);
      add_req(REQ_LOOK, 16'h7FFF, 16'h7FFF, 1, 16'hFFFF, DIR_RIGHT);
      add_req(REQ_LOOK, 16'h8000, 16'h8000, 1, 0, DIR_FWD);
      add_req(REQ_LOOK, 16'h7FFF, 16'h7FFF, 0, 0, DIR_FWD);
      add_req(REQ_LOOK, 16'h7FFF, 16'h7FFF, 0, 0, DIR_FWD);
      add_req(REQ_LOOK, 16'h8000, 16'h8000, 0, 0, DIR_FWD);
      add_req(REQ_LOOK, 0, 0, 1, 0, DIR_FWD);
      add_cfg(REG_MOVE_SPEED, 24'hFFFF);
      add_cfg(REG_LOOK_SENS, 24'hFFFF);
      add_cfg(REG_START_X, 24'h7FFFFF);
      add_cfg(REG_START_Y, 24'h800000);
      add_cfg(REG_START_Z, 24'h7FFF00);
      add_req(REQ_MOVE, 0, 0, 0, 16'hFFFF, DIR_FWD);
      add_req(REQ_MOVE, 0, 0, 0, 16'hFFFF, DIR_BACK);
      add_req(REQ_LOOK, 16'h0100, 16'hFF00, 1, 0, DIR_FWD);
      // zero world up: zero cross keeps the previous right
      add_cfg(REG_WUP_X, 24'h0);
      add_cfg(REG_WUP_Y, 24'h0);
      add_cfg(REG_WUP_Z, 24'h0);
      add_req(REQ_LOOK, 0, 0, 1, 0, DIR_FWD);
      add_cfg(4'd9, 24'hFFFFFF);
      add_cfg(REG_WUP_X, 24'h8000);
      add_cfg(REG_WUP_Z, 24'h7FFF);
      add_req(REQ_LOOK, 16'h0010, 16'h0010, 0, 0, DIR_FWD);
      add_random(700);
      add_cfg(REG_MOVE_SPEED, 24'h0);
      add_cfg(REG_LOOK_SENS, 24'h0);
      add_cfg(REG_WUP_Y, 24'h4000);
      add_random(300);
      for (int p = 0; p < 4; p++) begin
         add_cfg(REG_MOVE_SPEED, 24'($urandom));
         add_cfg(REG_LOOK_SENS, 24'($urandom));
         add_cfg(REG_WUP_X, 24'($urandom_range(0, 8000)) - 24'd4000);
         add_cfg(REG_WUP_Y, 24'($urandom));
         add_cfg(REG_WUP_Z, 24'($urandom_range(0, 8000)) - 24'd4000);
         add_cfg(REG_START_X, 24'($urandom));
         add_cfg(REG_START_Y, 24'($urandom));
         add_cfg(REG_START_Z, 24'($urandom));
         add_random(250);
      end
   end

   // driver
   int  gap_cnt = 0;
   int  settle_cnt = 0;
   bit  drv_done = 0;
   bit  req_taken = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_we <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the transaction
         csr_we <= 1'b0;
      end else if (gap_cnt > 0) begin
         req_tvalid <= 1'b0;
         csr_we <= 1'b0;
         gap_cnt <= gap_cnt - 1;
      end else if (pending_ops.size() == 0) begin
         req_tvalid <= 1'b0;
         csr_we <= 1'b0;
         drv_done <= 1;
      end else if (pending_ops[0].is_wait) begin
         req_tvalid <= 1'b0;
         csr_we <= 1'b0;
         // idle: nothing in flight, then a margin for the longest look
         if (pose_exp_q.size() != 0 || req_tvalid) settle_cnt <= 0;
         else if (settle_cnt < 400) settle_cnt <= settle_cnt + 1;
         else begin
            settle_cnt <= 0;
            void'(pending_ops.pop_front());
         end
      end else if (pending_ops[0].is_cfg) begin
         req_tvalid <= 1'b0;
         csr_we <= 1'b1;
         csr_index <= pending_ops[0].idx;
         csr_wdata <= pending_ops[0].val;
         apply_csr(pending_ops[0].idx, pending_ops[0].val);
         void'(pending_ops.pop_front());
      end else begin
         req_taken = 1'b0;
         csr_we <= 1'b0;
         req_tvalid <= 1'b1;
         req_tuser <= pending_ops[0].r.kind;
         req_tdata <= {pending_ops[0].r.dir, pending_ops[0].r.dt, pending_ops[0].r.clamp,
                       pending_ops[0].r.yo, pending_ops[0].r.xo};
         void'(pending_ops.pop_front());
         gap_cnt <= gap_len();
      end
   end

   // predict on acceptance
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         cam_req_type r;
         r.kind = req_tuser;
         r.xo = req_tdata[15:0];
         r.yo = req_tdata[31:16];
         r.clamp = req_tdata[32];
         r.dt = req_tdata[48:33];
         r.dir = req_tdata[50:49];
         pose_exp_q.push_back(predict_pose(r));
         req_taken = 1'b1;
      end
   end

   // receiver stalls
   int stall_cnt = 0;
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (stall_cnt > 0) begin
         rsp_tready <= 1'b0;
         stall_cnt <= stall_cnt - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_cnt <= gap_len();
         rsp_tready <= 1'b0;
      end else rsp_tready <= 1'b1;
   end

   // monitor
   logic [215:0] want;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pose_exp_q.size() == 0) begin
            $display("%t unexpected transaction %h", $realtime, rsp_tdata);
            failed = 1;
         end else begin
            want = pose_exp_q.pop_front();
            for (int k = 0; k < 3; k++)
               if (want[24*k +: 24] !== rsp_tdata[24*k +: 24]) begin
                  $display("%t pos[%0d] expected %h actual %h", $realtime, k,
                           want[24*k +: 24], rsp_tdata[24*k +: 24]);
                  failed = 1;
               end
            for (int k = 0; k < 9; k++)
               if (want[72 + 16*k +: 16] !== rsp_tdata[72 + 16*k +: 16]) begin
                  $display("%t vec[%0d] expected %h actual %h", $realtime, k,
                           want[72 + 16*k +: 16], rsp_tdata[72 + 16*k +: 16]);
                  failed = 1;
               end
         end
      end
   end

   // watchdog and end of run
   int idle_cyc = 0;
   int tail_cyc = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
         idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (drv_done && pose_exp_q.size() == 0) tail_cyc <= tail_cyc + 1;
      if (idle_cyc > 5000) begin
         $display("FAIL");
         $finish;
      end else if (tail_cyc > 400) begin
         if (!failed) $display("PASS");
         else $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end
endmodule

// File: sim.f
hw/rtl/ecou_pkg.sv
hw/rtl/ecou_cordic.sv
hw/rtl/ecou_root_div.sv
hw/rtl/euler_camera_orientation_update.sv
hw/rtl/ecou_checker.sv
tb/sv/tb.sv
